// ===== hw/rtl/lcdwin_pkg.sv =====
// Shared types and constants for the LCD window pixel writer.
package lcdwin_pkg;

  localparam int unsigned COORD_BITS_DEF = 9;
  localparam int unsigned REMAIN_BITS    = 18;
  localparam int unsigned MAX_BYTES      = 11;
  localparam int unsigned BYTE_CNT_BITS  = 4;
  localparam int unsigned CFG_IDX_BITS   = 3;
  localparam int unsigned CFG_DATA_BITS  = 16;
  localparam int unsigned COLOR_BITS     = 16;

  localparam logic [BYTE_CNT_BITS-1:0] WINDOW_BYTES = BYTE_CNT_BITS'(11);
  localparam logic [BYTE_CNT_BITS-1:0] PIXEL_BYTES  = BYTE_CNT_BITS'(2);

  localparam logic [COLOR_BITS-1:0] PAL0_RST = 16'd1363;
  localparam logic [COLOR_BITS-1:0] PAL1_RST = 16'd1069;
  localparam logic [COLOR_BITS-1:0] PAL2_RST = 16'd644;
  localparam logic [COLOR_BITS-1:0] PAL3_RST = 16'd288;
  localparam logic [7:0] COL_CMD_RST   = 8'd42;
  localparam logic [7:0] PAGE_CMD_RST  = 8'd43;
  localparam logic [7:0] MEMWR_CMD_RST = 8'd44;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_PAL_LIGHTEST = 3'd0,
    REG_PAL_LIGHT    = 3'd1,
    REG_PAL_DARK     = 3'd2,
    REG_PAL_DARKEST  = 3'd3,
    REG_COL_CMD      = 3'd4,
    REG_PAGE_CMD     = 3'd5,
    REG_MEMWR_CMD    = 3'd6
  } cfg_reg_e;

  typedef enum logic {
    ACT_WINDOW = 1'b0,
    ACT_PIXEL  = 1'b1
  } action_e;

  // One job handed to the byte sequencer: bytes in send order, index 0 first.
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0]    bytes;
    logic [MAX_BYTES-1:0]         is_data;
    logic [BYTE_CNT_BITS-1:0]     nbytes;
    logic                         done;
  } job_t;

endpackage

// ===== hw/rtl/lcdwin_serializer.sv =====
// Byte sequencer: holds one job and shifts its bytes into the output register.
module lcdwin_serializer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  input  lcdwin_pkg::job_t  job_i,
  output logic              job_ready_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        byte_out_o,
  output logic              is_data_o,
  output logic              run_last_o,
  output logic              window_done_o
);

  logic [lcdwin_pkg::BYTE_CNT_BITS-1:0]  cnt_q, cnt_d;
  logic [lcdwin_pkg::MAX_BYTES-1:0][7:0] bytes_q, bytes_d;
  logic [lcdwin_pkg::MAX_BYTES-1:0]      dat_q, dat_d;
  logic                                  done_q, done_d;
  logic                                  out_vld_q, out_vld_d;
  logic [7:0]                            out_byte_q;
  logic                                  out_dat_q, out_last_q, out_done_q;
  logic                                  emit, load, on_last;

  assign on_last     = (cnt_q == lcdwin_pkg::BYTE_CNT_BITS'(1));
  assign emit        = (cnt_q != '0) && (!out_vld_q || !out_stall_i);
  assign job_ready_o = (cnt_q == '0) || (on_last && emit);
  assign load        = job_valid_i && job_ready_o;

  always_comb begin
    cnt_d   = cnt_q;
    bytes_d = bytes_q;
    dat_d   = dat_q;
    done_d  = done_q;
    if (emit) begin
      cnt_d   = cnt_q - lcdwin_pkg::BYTE_CNT_BITS'(1);
      bytes_d = {8'h00, bytes_q[lcdwin_pkg::MAX_BYTES-1:1]};
      dat_d   = {1'b0, dat_q[lcdwin_pkg::MAX_BYTES-1:1]};
    end
    if (load) begin
      cnt_d   = job_i.nbytes;
      bytes_d = job_i.bytes;
      dat_d   = job_i.is_data;
      done_d  = job_i.done;
    end
  end

  // Hold a stalled word; drop it once taken unless a new one arrives.
  always_comb begin
    if (emit) begin
      out_vld_d = 1'b1;
    end else if (out_stall_i) begin
      out_vld_d = out_vld_q;
    end else begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bytes_q <= bytes_d;
    dat_q   <= dat_d;
    done_q  <= done_d;
    if (emit) begin
      out_byte_q <= bytes_q[0];
      out_dat_q  <= dat_q[0];
      out_last_q <= on_last;
      out_done_q <= done_q && on_last;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign byte_out_o    = out_byte_q;
  assign is_data_o     = out_dat_q;
  assign run_last_o    = out_last_q;
  assign window_done_o = out_done_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= lcdwin_pkg::BYTE_CNT_BITS'(lcdwin_pkg::MAX_BYTES))
    else $error("byte count beyond job size");

  a_load_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> cnt_q == $past(job_i.nbytes))
    else $error("job load lost its byte count");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_done_q |-> out_last_q && out_dat_q)
    else $error("window done flag off the last data word");

endmodule

// ===== hw/rtl/lcd_window_pixel_writer.sv =====
// Top level of the LCD window pixel writer: input register, job builder, config registers.
// Path: an accepted item passes the input register, the sequencer's job registers and its
// output register before its first word shows. Throughput: one word per cycle out of the
// byte sequencer while the output is not stalled; a window is 11 bytes, a pixel 2 bytes.
// The next item waits in the input register while the sequencer drains the current job.
// Reset: pixel counter cleared, palette and command registers at their defaults, no words.
module lcd_window_pixel_writer #(
  parameter int unsigned COORD_BITS = lcdwin_pkg::COORD_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // item channel
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 action_i,
  input  logic [COORD_BITS-1:0]                first_row_i,
  input  logic [COORD_BITS:0]                  row_count_i,
  input  logic [COORD_BITS-1:0]                first_column_i,
  input  logic [COORD_BITS:0]                  column_count_i,
  input  logic [1:0]                           color_index_i,
  // word channel
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [7:0]                           byte_out_o,
  output logic                                 is_data_o,
  output logic                                 run_last_o,
  output logic                                 window_done_o,
  // register write channel
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [lcdwin_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [lcdwin_pkg::CFG_DATA_BITS-1:0] cfg_data_i
);

  localparam int unsigned PROD_BITS = 2 * (COORD_BITS + 1);
  localparam logic [PROD_BITS-1:0] PROD_SAT =
    PROD_BITS'({lcdwin_pkg::REMAIN_BITS{1'b1}});

  // Input register: one item parked ahead of the sequencer.
  logic                  in_vld_q;
  logic                  action_q;
  logic [COORD_BITS-1:0] first_row_q, first_column_q;
  logic [COORD_BITS:0]   row_count_q, column_count_q;
  logic [1:0]            color_index_q;

  // Pixel counter and configuration.
  logic [lcdwin_pkg::REMAIN_BITS-1:0] remain_q, remain_d;
  logic [3:0][lcdwin_pkg::COLOR_BITS-1:0] pal_q;
  logic [7:0] col_cmd_q, page_cmd_q, memwr_cmd_q;

  logic                   is_pixel, drop, xfer, job_valid, job_ready;
  lcdwin_pkg::job_t       job;
  logic [15:0]            col0, col_end, row0, row_end, code;
  logic [PROD_BITS-1:0]   prod;

  assign is_pixel = (action_q == lcdwin_pkg::ACT_PIXEL);
  // A pixel with nothing left to draw is consumed without output.
  assign drop      = is_pixel && (remain_q == '0);
  assign job_valid = in_vld_q && !drop;
  assign xfer      = in_vld_q && (drop || job_ready);
  assign in_stall_o = in_vld_q && !xfer;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      action_q       <= action_i;
      first_row_q    <= first_row_i;
      row_count_q    <= row_count_i;
      first_column_q <= first_column_i;
      column_count_q <= column_count_i;
      color_index_q  <= color_index_i;
    end
  end

  // Window coordinates go out as 16-bit pairs; the end wraps modulo 2^16.
  assign col0    = 16'(first_column_q);
  assign col_end = col0 + 16'(column_count_q) - 16'd1;
  assign row0    = 16'(first_row_q);
  assign row_end = row0 + 16'(row_count_q) - 16'd1;
  assign prod    = PROD_BITS'(row_count_q) * PROD_BITS'(column_count_q);

  always_comb begin
    case (color_index_q)
      2'd0:    code = pal_q[0];
      2'd1:    code = pal_q[1];
      2'd2:    code = pal_q[2];
      2'd3:    code = pal_q[3];
      default: code = pal_q[0];
    endcase
  end

  // Build the job: the full window header, or the two color bytes.
  always_comb begin
    job = '0;
    if (is_pixel) begin
      job.bytes[0]   = code[15:8];
      job.bytes[1]   = code[7:0];
      job.is_data[1:0] = 2'b11;
      job.nbytes     = lcdwin_pkg::PIXEL_BYTES;
      job.done       = (remain_q == lcdwin_pkg::REMAIN_BITS'(1));
    end else begin
      job.bytes[0]   = col_cmd_q;
      job.bytes[1]   = col0[15:8];
      job.bytes[2]   = col0[7:0];
      job.bytes[3]   = col_end[15:8];
      job.bytes[4]   = col_end[7:0];
      job.bytes[5]   = page_cmd_q;
      job.bytes[6]   = row0[15:8];
      job.bytes[7]   = row0[7:0];
      job.bytes[8]   = row_end[15:8];
      job.bytes[9]   = row_end[7:0];
      job.bytes[10]  = memwr_cmd_q;
      job.is_data    = 11'b01111011110;
      job.nbytes     = lcdwin_pkg::WINDOW_BYTES;
      job.done       = 1'b0;
    end
  end

  // Load the counter on a window (saturating), decrement on each drawn pixel.
  always_comb begin
    remain_d = remain_q;
    if (xfer) begin
      if (!is_pixel) begin
        remain_d = (prod > PROD_SAT) ? '1 : lcdwin_pkg::REMAIN_BITS'(prod);
      end else if (!drop) begin
        remain_d = remain_q - lcdwin_pkg::REMAIN_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      remain_q    <= '0;
      pal_q[0]    <= lcdwin_pkg::PAL0_RST;
      pal_q[1]    <= lcdwin_pkg::PAL1_RST;
      pal_q[2]    <= lcdwin_pkg::PAL2_RST;
      pal_q[3]    <= lcdwin_pkg::PAL3_RST;
      col_cmd_q   <= lcdwin_pkg::COL_CMD_RST;
      page_cmd_q  <= lcdwin_pkg::PAGE_CMD_RST;
      memwr_cmd_q <= lcdwin_pkg::MEMWR_CMD_RST;
    end else begin
      remain_q <= remain_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          lcdwin_pkg::REG_PAL_LIGHTEST: pal_q[0]    <= cfg_data_i;
          lcdwin_pkg::REG_PAL_LIGHT:    pal_q[1]    <= cfg_data_i;
          lcdwin_pkg::REG_PAL_DARK:     pal_q[2]    <= cfg_data_i;
          lcdwin_pkg::REG_PAL_DARKEST:  pal_q[3]    <= cfg_data_i;
          lcdwin_pkg::REG_COL_CMD:      col_cmd_q   <= cfg_data_i[7:0];
          lcdwin_pkg::REG_PAGE_CMD:     page_cmd_q  <= cfg_data_i[7:0];
          lcdwin_pkg::REG_MEMWR_CMD:    memwr_cmd_q <= cfg_data_i[7:0];
          default: ;
        endcase
      end
    end
  end

  lcdwin_serializer u_serializer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_valid_i   (job_valid),
    .job_i         (job),
    .job_ready_o   (job_ready),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .byte_out_o    (byte_out_o),
    .is_data_o     (is_data_o),
    .run_last_o    (run_last_o),
    .window_done_o (window_done_o)
  );

  a_park_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !xfer |=> in_vld_q && $stable(action_q))
    else $error("parked item lost before hand-off");

  a_pixel_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer && is_pixel && !drop |=>
      remain_q == lcdwin_pkg::REMAIN_BITS'($past(remain_q) - 1'b1))
    else $error("pixel counter did not step");

  a_empty_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer && !is_pixel && (column_count_q == '0) |=> remain_q == '0)
    else $error("zero-width window left pixels pending");

endmodule
